>>> src/tcfs_pkg.sv
package tcfs_pkg;

  // opcodes of an input word
  localparam logic [1:0] OP_CHECK   = 2'd0;
  localparam logic [1:0] OP_PRELOAD = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam int unsigned FIELD_BITS = 16;
  localparam logic [15:0] REJ_MAX    = 16'hFFFF;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] subject;
    logic [15:0] predicate;
    logic [15:0] object_value;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        conflict;
    logic [9:0]  conflict_slot;
    logic        status;
    logic [10:0] stored_count;
    logic [15:0] rejected_total;
  } result_t;

endpackage

>>> src/triple_conflict_filter_store_top.sv
// Timing: clear, preload, unused opcode, full store and empty-store check give their
//   result in the cycle after start; a new word can be taken every cycle. A check on
//   N entries holds busy while it scans them, ending early on a conflict, and gives
//   its result at the scan's end, when the next word can be taken; one entry per
//   cycle on the memory's single read port sets it; the receiver cannot stall results.
// Reset: rst (synchronous) empties the store and clears both counters; memory
//   contents are not cleared, only entries below the fill count are ever read.
module triple_conflict_filter_store_top #(
  parameter int unsigned DEPTH   = 1024,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tcfs_pkg::item_t     item,
  output logic                done,
  output tcfs_pkg::result_t   result
);

  // identifiers are taken in their low ID_BITS bits, at most the 16 the fields hold
  localparam int unsigned KEY_BITS = (ID_BITS < tcfs_pkg::FIELD_BITS) ?
                                     ID_BITS : tcfs_pkg::FIELD_BITS;
  localparam int unsigned ENT_BITS = 3 * KEY_BITS;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  // entry memory: one write port, one registered read port
  logic [ENT_BITS-1:0] mem [DEPTH];
  logic [ENT_BITS-1:0] rd_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENT_BITS-1:0] wr_data;

  // control state
  tcfs_pkg::state_t state, state_next;
  logic [CNT_W-1:0]  fill, fill_next;
  logic [15:0]       rej, rej_next;
  logic [ADDR_W-1:0] idx, idx_next;      // entry whose data arrives this cycle
  logic              done_next;
  tcfs_pkg::result_t result_next;

  // word under check, held for the scan
  logic [KEY_BITS-1:0] key_s, key_p, key_o;
  logic                key_load;

  logic [KEY_BITS-1:0] in_s, in_p, in_o;
  logic [KEY_BITS-1:0] ent_s, ent_p, ent_o;
  logic                hit;
  logic                last;

  assign in_s = item.subject[KEY_BITS-1:0];
  assign in_p = item.predicate[KEY_BITS-1:0];
  assign in_o = item.object_value[KEY_BITS-1:0];

  assign ent_s = rd_data[ENT_BITS-1 -: KEY_BITS];
  assign ent_p = rd_data[2*KEY_BITS-1 -: KEY_BITS];
  assign ent_o = rd_data[KEY_BITS-1:0];

  // same subject and predicate, different object
  assign hit  = (ent_s == key_s) && (ent_p == key_p) && (ent_o != key_o);
  assign last = ((CNT_W'(idx) + CNT_W'(1)) == fill);

  assign busy = (state != tcfs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (key_load) begin
      key_s <= in_s;
      key_p <= in_p;
      key_o <= in_o;
    end
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcfs_pkg::ST_IDLE;
      fill  <= '0;
      rej   <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      rej   <= rej_next;
      idx   <= idx_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    rej_next    = rej;
    idx_next    = idx;
    done_next   = 1'b0;
    key_load    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = fill[ADDR_W-1:0];
    wr_data     = {key_s, key_p, key_o};
    result_next = '0;

    unique case (state)
      tcfs_pkg::ST_IDLE: begin
        if (start) begin
          key_load  = 1'b1;
          done_next = 1'b1;
          wr_data   = {in_s, in_p, in_o};
          unique case (item.opcode) inside
            tcfs_pkg::OP_CLEAR: begin
              fill_next = '0;
              rej_next  = '0;
            end
            tcfs_pkg::OP_CHECK, tcfs_pkg::OP_PRELOAD: begin
              if (fill == FULL) begin
                result_next.status = 1'b1;
              end else if (item.opcode == tcfs_pkg::OP_CHECK && fill != '0) begin
                // start the scan at entry 0; result comes at its end
                done_next  = 1'b0;
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = tcfs_pkg::ST_SCAN;
              end else begin
                wr_en                = 1'b1;
                fill_next            = fill + CNT_W'(1);
                result_next.accepted = 1'b1;
              end
            end
            default: begin
              // unused opcode: report counters unchanged
            end
          endcase
          result_next.stored_count   = 11'(fill_next);
          result_next.rejected_total = rej_next;
        end
      end

      tcfs_pkg::ST_SCAN: begin
        if (hit) begin
          if (rej != tcfs_pkg::REJ_MAX) begin
            rej_next = rej + 16'd1;
          end
          done_next                 = 1'b1;
          result_next.conflict      = 1'b1;
          result_next.conflict_slot = 10'(idx);
          state_next                = tcfs_pkg::ST_IDLE;
        end else if (last) begin
          // scan clean: append behind the last entry read
          wr_en                = 1'b1;
          fill_next            = fill + CNT_W'(1);
          done_next            = 1'b1;
          result_next.accepted = 1'b1;
          state_next           = tcfs_pkg::ST_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx + ADDR_W'(1);
          idx_next = idx + ADDR_W'(1);
        end
        result_next.stored_count   = 11'(fill_next);
        result_next.rejected_total = rej_next;
      end

      default: begin
        state_next = tcfs_pkg::ST_IDLE;
      end
    endcase
  end

  // results only come out with the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  a_acc_fill: assert property (@(posedge clk) disable iff (rst)
    (done && result.accepted) |-> (fill == $past(fill) + CNT_W'(1)))
    else $error("append did not advance fill count");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.accepted && result.conflict)
             && !(result.status && (result.accepted || result.conflict)))
    else $error("result flags inconsistent");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == tcfs_pkg::ST_SCAN) |-> (fill != '0 && fill != FULL))
    else $error("scan with empty or full store");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count beyond depth");

endmodule
